### src/ring_buffer_deque_assert.svh
// Assertion macros for the ring_buffer_deque block.
// No dependencies; taken in by `include from the RTL file that checks itself.
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RBD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define RBD_ASSERT_ALWAYS(label, clk, rst, cond)
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/rbd_pkg.sv
// Shared types for the ring_buffer_deque block: opcodes, status codes, cell control.
// No dependencies.
package rbd_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic clear;
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_ctrl_type;

endpackage

### src/rbd_cell.sv
// One storage cell of the deque row: holds one word and its valid bit.
// Depends on rbd_pkg (cell_ctrl_type).
module rbd_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbd_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]  push_word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic                   left_valid,
   input  logic [DATA_WIDTH-1:0]  right_data,
   input  logic                   right_valid,
   input  logic [DATA_WIDTH-1:0]  tail_acc_in,
   output logic [DATA_WIDTH-1:0]  tail_acc_out,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   valid
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;
   logic                  is_tail;

   // last occupied cell: valid here, empty to the right
   assign is_tail      = valid_ff & ~right_valid;
   assign tail_acc_out = tail_acc_in | (is_tail ? data_ff : '0);
   assign data         = data_ff;
   assign valid        = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_back) begin
         if (left_valid & ~valid_ff) begin
            data_in  = push_word;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_back) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### src/ring_buffer_deque.sv
// Top level of the deque: a row of DEPTH rbd_cell instances, entry count and capacity.
// A result beat is registered and appears in the cycle after its request is accepted.
// One request per cycle unless stalled; each op not refused shifts or updates the cell
// row once. Reset (synchronous): deque empty, count zero, capacity DEPTH; a capacity
// write also empties the deque. Depends on rbd_pkg, rbd_cell and the assert header.
`include "ring_buffer_deque_assert.svh"

module ring_buffer_deque #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_capacity,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_push_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pop_value,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_pop_value_ff;
   logic [1:0]            rsp_status_ff;
   logic [6:0]            rsp_occupancy_ff;

   logic                  accept;
   logic                  full, empty;
   logic [31:0]           cap_req;
   logic [63:0]           push_ext;
   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] pop_word;
   logic [63:0]           pop_ext;
   rbd_pkg::op_type       op;
   rbd_pkg::status_type   status;
   rbd_pkg::cell_ctrl_type ctrl;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DATA_WIDTH-1:0] tail_acc [DEPTH+1];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign op        = rbd_pkg::op_type'(req_opcode);
   assign full      = count_ff >= cap_ff;
   assign empty     = count_ff == '0;

   assign push_ext  = {{32{req_push_value[31]}}, req_push_value};
   assign push_word = push_ext[DATA_WIDTH-1:0];

   // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
   assign cap_req = 32'(csr_capacity);
   always_comb begin
      priority if (cap_req == 32'd0) begin
         cap_in = CNT_W'(1);
      end else if (cap_req > 32'(DEPTH)) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = CNT_W'(cap_req);
      end
   end

   always_comb begin
      ctrl       = '0;
      ctrl.clear = csr_wr_en;
      count_in   = count_ff;
      status     = rbd_pkg::ST_OK;
      pop_word   = '0;
      if (accept) begin
         unique case (op)
            rbd_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status = rbd_pkg::ST_FULL;
               end else begin
                  ctrl.push_front = 1'b1;
                  count_in        = count_ff + CNT_W'(1);
               end
            end
            rbd_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status = rbd_pkg::ST_FULL;
               end else begin
                  ctrl.push_back = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
            end
            rbd_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status = rbd_pkg::ST_EMPTY;
               end else begin
                  ctrl.pop_front = 1'b1;
                  pop_word       = cell_data[0];
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            rbd_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status = rbd_pkg::ST_EMPTY;
               end else begin
                  ctrl.pop_back = 1'b1;
                  pop_word      = tail_acc[DEPTH];
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status = rbd_pkg::ST_OK;
            end
         endcase
      end
      if (csr_wr_en) begin
         count_in = '0;
      end
   end

   assign pop_ext      = 64'(pop_word);
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   assign tail_acc[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_data  = push_word;
         assign left_valid = 1'b1;
      end else begin : g_inner_l
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_r
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      rbd_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .push_word    (push_word),
         .left_data    (left_data),
         .left_valid   (left_valid),
         .right_data   (right_data),
         .right_valid  (right_valid),
         .tail_acc_in  (tail_acc[i]),
         .tail_acc_out (tail_acc[i+1]),
         .data         (cell_data[i]),
         .valid        (cell_valid[i])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pop_value_ff <= pop_ext[31:0];
         rsp_status_ff    <= status;
         rsp_occupancy_ff <= 7'(count_in);
      end
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= cap_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   `RBD_ASSERT_ALWAYS(a_count_le_cap, clock, reset, count_ff <= cap_ff)
   `RBD_ASSERT_ALWAYS(a_count_matches_cells, clock, reset, $countones(cell_valid) == count_ff)
   `RBD_ASSERT_NEXT(a_full_reported, clock, reset, accept && full && !req_opcode[1], rsp_status == rbd_pkg::ST_FULL)
   `RBD_ASSERT_NEXT(a_empty_pop_zero, clock, reset, accept && empty && req_opcode[1], rsp_pop_value == 32'd0 && rsp_status == rbd_pkg::ST_EMPTY)
   `RBD_ASSERT_ALWAYS(a_stall_backpressure, clock, reset, !(rsp_valid && rsp_stall) || req_stall)

endmodule

### verif/ring_buffer_deque_tb.sv
// Self-checking testbench for ring_buffer_deque: directed and bursty random push/pop beats
// checked against a cycle-free deque predictor across several capacity settings.
// Depends on rbd_pkg and the ring_buffer_deque RTL.
module ring_buffer_deque_tb;

   localparam int DEPTH     = 64;
   localparam int LONG_HOLD = 300;
   localparam int SEGMENTS  = 10;
   localparam int SEG_ITEMS = 150;

   typedef struct {
      rbd_pkg::op_type op;
      logic [31:0]     value;
   } deque_req_type;

   typedef struct {
      logic [31:0]         pop_value;
      rbd_pkg::status_type status;
      logic [6:0]          occupancy;
   } deque_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_capacity = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_push_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pop_value;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_occupancy;

   logic        hold_request = 1'b0;
   int          hold_left;
   int          send_idle_pct;
   int          recv_idle_pct;

   deque_req_type    pending_reqs[$];
   deque_result_type expected_results[$];
   int               items_queued;
   int               items_accepted;
   int               mismatches;
   int               cap_writes;
   int               words_popped;
   int               full_refusals;
   int               empty_refusals;

   // predictor state
   logic [31:0] shadow_words[DEPTH];
   logic [5:0]  shadow_head;
   logic [5:0]  shadow_tail;
   logic [6:0]  shadow_count;
   logic [6:0]  shadow_cap;

   ring_buffer_deque #(.DEPTH(DEPTH), .DATA_WIDTH(32)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_capacity   (csr_capacity),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   always #1 clock = ~clock;

   function automatic logic [6:0] clamp_capacity(logic [6:0] v);
      if (v == 0) return 7'd1;
      if (v > DEPTH) return 7'(DEPTH);
      return v;
   endfunction

   function automatic logic [5:0] ring_next(logic [5:0] i);
      return (7'(i) + 7'd1 >= shadow_cap) ? 6'd0 : i + 6'd1;
   endfunction

   function automatic logic [5:0] ring_prev(logic [5:0] i);
      return (i == 0) ? 6'(shadow_cap - 7'd1) : i - 6'd1;
   endfunction

   function automatic deque_result_type predict_deque_op(rbd_pkg::op_type op,
                                                         logic [31:0] word);
      deque_result_type r;
      r.pop_value = '0;
      r.status    = rbd_pkg::ST_OK;
      unique case (op)
         rbd_pkg::OP_PUSH_FRONT, rbd_pkg::OP_PUSH_BACK: begin
            if (shadow_count >= shadow_cap) begin
               r.status = rbd_pkg::ST_FULL;
               full_refusals++;
            end else if (op == rbd_pkg::OP_PUSH_FRONT) begin
               shadow_head = ring_prev(shadow_head);
               shadow_words[shadow_head] = word;
               shadow_count++;
            end else begin
               shadow_words[shadow_tail] = word;
               shadow_tail = ring_next(shadow_tail);
               shadow_count++;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = rbd_pkg::ST_EMPTY;
               empty_refusals++;
            end else if (op == rbd_pkg::OP_POP_FRONT) begin
               r.pop_value = shadow_words[shadow_head];
               shadow_head = ring_next(shadow_head);
               shadow_count--;
               words_popped++;
            end else begin
               shadow_tail = ring_prev(shadow_tail);
               r.pop_value = shadow_words[shadow_tail];
               shadow_count--;
               words_popped++;
            end
         end
      endcase
      r.occupancy = shadow_count;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      deque_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_opcode     <= nxt.op;
            req_push_value <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall, with a counted long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: check result beats, track capacity writes, predict accepted beats
   always @(posedge clock) begin
      deque_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result beat: value %h status %0d occ %0d",
                           rsp_pop_value, rsp_status, rsp_occupancy);
            end else begin
               e = expected_results.pop_front();
               if (rsp_pop_value !== e.pop_value || rsp_status !== e.status ||
                   rsp_occupancy !== e.occupancy) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: expected value %h status %0d occ %0d, got %h %0d %0d",
                              e.pop_value, e.status, e.occupancy,
                              rsp_pop_value, rsp_status, rsp_occupancy);
               end
            end
         end
         if (csr_wr_en) begin
            shadow_cap   = clamp_capacity(csr_capacity);
            shadow_head  = '0;
            shadow_tail  = '0;
            shadow_count = '0;
            cap_writes++;
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(
               predict_deque_op(rbd_pkg::op_type'(req_opcode), req_push_value));
            items_accepted++;
         end
      end
   end

   task automatic queue_op(rbd_pkg::op_type op, logic [31:0] word);
      deque_req_type r;
      r.op    = op;
      r.value = word;
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (items_accepted != items_queued || expected_results.size() != 0);
   endtask

   task automatic write_capacity(logic [6:0] v);
      wait_idle();
      csr_wr_en    <= 1'b1;
      csr_capacity <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      unique case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // bursts that lean toward pushes or pops so full and empty both get reached
   task automatic queue_random(int count, int cap);
      int  len;
      int  lean;
      bit  fill;
      fill = 1'b1;
      while (count > 0) begin
         len  = $urandom_range(2 * cap + 2, 1);
         lean = ($urandom_range(4) == 0) ? 50 : 85;
         for (int i = 0; i < len && count > 0; i++) begin
            if (($urandom_range(99) < lean) == fill)
               queue_op($urandom_range(1) ? rbd_pkg::OP_PUSH_BACK : rbd_pkg::OP_PUSH_FRONT,
                        pick_word());
            else
               queue_op($urandom_range(1) ? rbd_pkg::OP_POP_BACK : rbd_pkg::OP_POP_FRONT,
                        $urandom);
            count--;
         end
         fill = ~fill;
      end
   endtask

   initial begin
      logic [6:0] cap_plan[SEGMENTS];
      cap_plan = '{7'd1, 7'd2, 7'd64, 7'd7, 7'd65,
                   7'd3, 7'd33, 7'd0, 7'd127, 7'd5};
      send_idle_pct = 30;
      recv_idle_pct = 50;
      shadow_cap   = 7'(DEPTH);
      shadow_head  = '0;
      shadow_tail  = '0;
      shadow_count = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset capacity, both ends, extreme words, empty refusals
      queue_op(rbd_pkg::OP_POP_FRONT, 32'h1111_1111);
      queue_op(rbd_pkg::OP_POP_BACK, 32'h2222_2222);
      queue_op(rbd_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
      queue_op(rbd_pkg::OP_PUSH_BACK, 32'h8000_0000);
      queue_op(rbd_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      queue_op(rbd_pkg::OP_PUSH_BACK, 32'hffff_ffff);
      queue_op(rbd_pkg::OP_POP_FRONT, '0);
      queue_op(rbd_pkg::OP_POP_BACK, '0);
      queue_op(rbd_pkg::OP_POP_BACK, '0);
      queue_op(rbd_pkg::OP_POP_FRONT, '0);
      queue_op(rbd_pkg::OP_POP_FRONT, '0);

      // zero capacity acts as one: full refusals at both ends
      write_capacity(7'd0);
      queue_op(rbd_pkg::OP_PUSH_BACK, 32'h0000_1234);
      queue_op(rbd_pkg::OP_PUSH_FRONT, 32'hdead_beef);
      queue_op(rbd_pkg::OP_PUSH_BACK, 32'hdead_beef);
      queue_op(rbd_pkg::OP_POP_BACK, '0);
      queue_op(rbd_pkg::OP_POP_FRONT, '0);
      queue_op(rbd_pkg::OP_PUSH_FRONT, 32'haaaa_5555);

      // over-range capacity clamps to DEPTH, and the write empties the deque
      write_capacity(7'd127);
      queue_op(rbd_pkg::OP_POP_BACK, '0);

      for (int s = 0; s < SEGMENTS; s++) begin
         write_capacity(cap_plan[s]);
         if (s < 4) begin
            send_idle_pct = 30;
            recv_idle_pct = 50;
         end else if (s < 7) begin
            send_idle_pct = 50;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random(SEG_ITEMS, clamp_capacity(cap_plan[s]));
      end

      // long result hold-off while beats keep coming
      write_capacity(7'd64);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (int i = 0; i < 80; i++) queue_op(rbd_pkg::OP_PUSH_BACK, pick_word());
      for (int i = 0; i < 80; i++) queue_op(rbd_pkg::OP_POP_BACK, '0);

      wait_idle();
      repeat (8) @(posedge clock);
      mismatches += expected_results.size();

      $display("Ran %0d beats over %0d capacity writes: %0d words popped,",
               items_accepted, cap_writes, words_popped);
      $display("%0d full and %0d empty refusals.", full_refusals, empty_refusals);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Timeout: %0d of %0d beats accepted", items_accepted, items_queued);
      $display("Test completed with failures");
      $finish;
   end

endmodule
